@@ rtl/weighted_smoothing_3x3_assert.svh @@
// Assertion macros for the weighted 3x3 smoothing RTL.
// The macros expect the including module to have i_clk and i_rst_n.
`ifndef WEIGHTED_SMOOTHING_3X3_ASSERT_SVH
`define WEIGHTED_SMOOTHING_3X3_ASSERT_SVH

// Checks a consequence in the same cycle as its antecedent.
`define WSM3_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define WSM3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wsm3_pkg.sv @@
// Shared types and constants for the weighted 3x3 smoothing block.
// No dependencies; used by the divider unit and the top level.
package wsm3_pkg;

    localparam int LINE_MAX_DEF = 512;
    localparam int SAMPLE_W_DEF = 24;

    localparam int ROWS_W    = 13;
    localparam int COLS_W    = 10;
    localparam int ROW_CNT_W = 12;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd200;
    localparam logic [COLS_W-1:0] COLS_RESET = 10'd401;
    localparam logic [ROWS_W-1:0] ROWS_MIN   = 13'd3;
    localparam logic [ROWS_W-1:0] ROWS_MAX   = 13'd4096;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

    // Control that travels alongside a result through the divider stages.
    typedef struct packed {
        logic valid;
        logic last;
    } t_div_ctl;

endpackage

@@ rtl/wsm3_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module wsm3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/wsm3_div12.sv @@
// Weighted sum, round half up, divide by 12 and saturate, in three stages.
// Depends on wsm3_pkg for the control struct.
module wsm3_div12 #(
    parameter int SAMPLE_W = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  wsm3_pkg::t_div_ctl         i_ctl,
    input  logic signed [SAMPLE_W+1:0] i_p0,
    input  logic signed [SAMPLE_W+1:0] i_p1,
    input  logic signed [SAMPLE_W-1:0] i_p2,
    output wsm3_pkg::t_div_ctl         o_ctl,
    output logic [SAMPLE_W-1:0]        o_result
);
    import wsm3_pkg::*;

    localparam int SW    = SAMPLE_W;
    localparam int SUM_W = SW + 4;
    localparam int U_W   = SW + 3;
    localparam int K     = SW + 4;
    localparam int P_W   = 2 * U_W;
    localparam logic [63:0] MAGIC64 = ((64'd1 << K) + 64'd2) / 64'd3;
    localparam logic [U_W-1:0] MAGIC = MAGIC64[U_W-1:0];
    localparam logic [U_W-1:0] U_OFF = {2'b11, {(SW+1){1'b0}}};
    localparam logic signed [U_W-1:0] Q_OFF = {2'b01, {(SW+1){1'b0}}};
    localparam logic signed [U_W-1:0] Q_HI  = {4'b0000, {(SW-1){1'b1}}};
    localparam logic signed [U_W-1:0] Q_LO  = {4'b1111, {(SW-1){1'b0}}};

    t_div_ctl r_ctl_a, r_ctl_b, r_ctl_c;
    logic signed [SW+1:0] r_p0, r_p1;
    logic signed [SW-1:0] r_p2;
    logic [U_W-1:0] r_u;
    logic [P_W-1:0] r_prod;

    logic signed [SUM_W-1:0] sum;
    logic signed [SW+1:0]    m;
    logic signed [U_W-1:0]   m_x;
    logic [U_W-1:0]          u;
    logic [SW+1:0]           q_u;
    logic signed [U_W-1:0]   q_s;

    // floor((sum + 6) / 12) = floor(floor((sum + 6) / 4) / 3). The offset makes
    // the dividend positive so that a reciprocal multiply gives floor(u / 3).
    always_comb begin
        sum = SUM_W'(r_p0) + (SUM_W'(r_p1) <<< 1) + (SUM_W'(r_p2) <<< 2) + SUM_W'(6);
        m   = sum[SUM_W-1:2];
        m_x = U_W'(m);
        u   = unsigned'(m_x) + U_OFF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= i_p0;
            r_p1   <= i_p1;
            r_p2   <= i_p2;
            r_u    <= u;
            r_prod <= r_u * MAGIC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
            r_ctl_c <= r_ctl_b;
        end
    end

    always_comb begin
        q_u = r_prod[P_W-1:K];
        q_s = signed'({1'b0, q_u}) - Q_OFF;
        if (q_s > Q_HI) begin
            o_result = Q_HI[SW-1:0];
        end else if (q_s < Q_LO) begin
            o_result = Q_LO[SW-1:0];
        end else begin
            o_result = q_s[SW-1:0];
        end
    end

    assign o_ctl = r_ctl_c;

endmodule

@@ rtl/weighted_smoothing_3x3.sv @@
// Top level of the weighted 3x3 smoothing filter for a raster sample stream.
// Depends on wsm3_pkg, wsm3_ram, wsm3_div12 and weighted_smoothing_3x3_assert.svh.
//
//   Channel   Direction  Handshake                        Payload
//   sample    in         i_sample_valid / o_sample_ready  i_sample_in
//   result    out        o_result_valid / i_result_ready  o_smoothed, o_last_of_frame
//   config    in         i_cfg_we (no wait)               i_cfg_idx, i_cfg_data
//
// One sample request is taken every clock cycle while the output side keeps up;
// each line store has one read and one write port, so one column is handled per cycle.
// A window's last request goes via stage one, the divider and the output register.
// Reset is synchronous and clears the counters, window and valid bits;
// the line stores are not cleared, so an entry read before it is written is undefined.
// When the consumer stalls, a skid register catches the one result in flight and the
// whole pipeline then holds until the skid register drains.
module weighted_smoothing_3x3 #(
    parameter int LINE_MAX = wsm3_pkg::LINE_MAX_DEF,
    parameter int SAMPLE_W = wsm3_pkg::SAMPLE_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wsm3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wsm3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_sample_valid,
    output logic                              o_sample_ready,
    input  logic signed [SAMPLE_W-1:0]        i_sample_in,
    output logic                              o_result_valid,
    input  logic                              i_result_ready,
    output logic signed [SAMPLE_W-1:0]        o_smoothed,
    output logic                              o_last_of_frame
);
    import wsm3_pkg::*;

    `include "weighted_smoothing_3x3_assert.svh"

    localparam int CW = $clog2(LINE_MAX);
    localparam int XW = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;
    localparam logic [XW-1:0] COLS_MIN_X = XW'(3);
    localparam logic [XW-1:0] COLS_MAX_X = XW'(LINE_MAX);
    localparam int SW = SAMPLE_W;

    // Config registers. Writes must arrive only while the block is idle; it is unchecked.
    logic [ROWS_W-1:0] r_frame_rows;
    logic [COLS_W-1:0] r_frame_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= ROWS_RESET;
            r_frame_cols <= COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_ROWS: r_frame_rows <= i_cfg_data[ROWS_W-1:0];
                REG_FRAME_COLS: r_frame_cols <= i_cfg_data[COLS_W-1:0];
            endcase
        end
    end

    // Clamp the frame size to its legal range and derive the last indexes.
    logic [ROWS_W-1:0]    rows_eff;
    logic [XW-1:0]        cols_x, cols_eff;
    logic [ROW_CNT_W-1:0] last_row;
    logic [CW-1:0]        last_col;

    always_comb begin
        if (r_frame_rows < ROWS_MIN) begin
            rows_eff = ROWS_MIN;
        end else if (r_frame_rows > ROWS_MAX) begin
            rows_eff = ROWS_MAX;
        end else begin
            rows_eff = r_frame_rows;
        end
        cols_x = XW'(r_frame_cols);
        if (cols_x < COLS_MIN_X) begin
            cols_eff = COLS_MIN_X;
        end else if (cols_x > COLS_MAX_X) begin
            cols_eff = COLS_MAX_X;
        end else begin
            cols_eff = cols_x;
        end
        last_row = ROW_CNT_W'(rows_eff - ROWS_W'(1));
        last_col = CW'(cols_eff - XW'(1));
    end

    // The pipeline advances as a whole unless the output skid register is full.
    logic r_skd_valid;
    logic en;
    logic accept;

    assign en             = !r_skd_valid;
    assign o_sample_ready = en;
    assign accept         = i_sample_valid && en;

    // Position counters. The line store read for a column is issued with the
    // request, so the registered read data lines up with the sample in stage one.
    logic [ROW_CNT_W-1:0] r_row;
    logic [CW-1:0]        r_col;
    logic                 col_end, row_end;

    assign col_end = (r_col >= last_col);
    assign row_end = (r_row >= last_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + ROW_CNT_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Stage one: the sample and its flags, waiting for the line store data.
    logic                 r_s1_valid;
    logic signed [SW-1:0] r_s1_sample;
    logic [CW-1:0]        r_s1_col;
    logic                 r_s1_emit;
    logic                 r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= i_sample_in;
            r_s1_col    <= r_col;
            r_s1_emit   <= (r_row >= ROW_CNT_W'(2)) && (r_col >= CW'(2));
            r_s1_last   <= col_end && row_end;
        end
    end

    // Line store a holds the row above, line store b the row above that. The
    // write of a column is issued from stage one, after its read; the next read of the
    // same column is a full row later, so no forwarding is needed.
    logic [SW-1:0] lsa_rdata, lsb_rdata;
    logic          ls_we;

    assign ls_we = en && r_s1_valid;

    wsm3_ram #(
        .WIDTH (SW),
        .DEPTH (LINE_MAX)
    ) u_line_store_a (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_sample),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (lsa_rdata)
    );

    wsm3_ram #(
        .WIDTH (SW),
        .DEPTH (LINE_MAX)
    ) u_line_store_b (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (r_s1_col),
        .i_wdata (lsa_rdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (lsb_rdata)
    );

    // Window: two previous columns for the top, middle and bottom rows.
    // Even entries hold column minus one, odd entries column minus two.
    logic signed [SW-1:0] r_win [6];
    logic signed [SW-1:0] top, mid;

    assign top = signed'(lsb_rdata);
    assign mid = signed'(lsa_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (ls_we) begin
            r_win[0] <= top;
            r_win[1] <= r_win[0];
            r_win[2] <= mid;
            r_win[3] <= r_win[2];
            r_win[4] <= r_s1_sample;
            r_win[5] <= r_win[4];
        end
    end

    // Partial sums by weight: corners, edges and the centre.
    logic signed [SW+1:0] p_corner, p_edge;
    t_div_ctl             div_in_ctl, div_out_ctl;
    logic [SW-1:0]        div_result;

    always_comb begin
        p_corner = (SW+2)'(r_win[1]) + (SW+2)'(top) + (SW+2)'(r_win[5])
                 + (SW+2)'(r_s1_sample);
        p_edge   = (SW+2)'(r_win[0]) + (SW+2)'(r_win[3]) + (SW+2)'(mid)
                 + (SW+2)'(r_win[4]);
        div_in_ctl.valid = r_s1_valid && r_s1_emit;
        div_in_ctl.last  = r_s1_last;
    end

    wsm3_div12 #(
        .SAMPLE_W (SW)
    ) u_div12 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (div_in_ctl),
        .i_p0     (p_corner),
        .i_p1     (p_edge),
        .i_p2     (r_win[2]),
        .o_ctl    (div_out_ctl),
        .o_result (div_result)
    );

    // Output register with a skid register behind it. A result that arrives
    // while the output is stalled goes to the skid register, which then stops
    // the pipeline until it drains.
    logic          r_out_valid;
    logic [SW-1:0] r_out_data, r_skd_data;
    logic          r_out_last, r_skd_last;
    logic          out_free;
    logic          up_valid;

    assign out_free = !r_out_valid || i_result_ready;
    assign up_valid = div_out_ctl.valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= up_valid;
            end
        end else if (up_valid) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skd_valid) begin
                r_out_data <= r_skd_data;
                r_out_last <= r_skd_last;
            end else begin
                r_out_data <= div_result;
                r_out_last <= div_out_ctl.last;
            end
        end else if (up_valid) begin
            r_skd_data <= div_result;
            r_skd_last <= div_out_ctl.last;
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_smoothed      = signed'(r_out_data);
    assign o_last_of_frame = r_out_last;

    `WSM3_ASSERT_SAME(a_skid_behind_out, r_skd_valid, r_out_valid, "skid full with output empty")
    `WSM3_ASSERT_SAME(a_ls_no_collision, ls_we && accept, r_s1_col != r_col, "line store clash")
    `WSM3_ASSERT_NEXT(a_col_wraps, accept && col_end, r_col == '0, "column did not wrap")
    `WSM3_ASSERT_SAME(a_last_is_interior, ls_we && r_s1_last, r_s1_emit, "last flag on border")

endmodule

@@ test/tb_weighted_smoothing_3x3.sv @@
// Self-checking testbench for weighted_smoothing_3x3, the 3x3 weighted smoothing filter.
// Depends on wsm3_pkg and the RTL of weighted_smoothing_3x3 with its submodules.
// Samples go in through a queued driver; a monitor checks results against a built-in model.
module tb_weighted_smoothing_3x3;
    import wsm3_pkg::*;

    localparam int SW           = SAMPLE_W_DEF;
    localparam int LINES        = LINE_MAX_DEF;
    localparam int COLS_MIN     = 3;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    // The result path is five stages plus a skid register, so this is a safe settling time.
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 100;
    localparam int CYCLE_LIMIT  = 500000;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam longint SAT_HI = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) << (SW - 1));

    typedef struct packed {
        logic [SW-1:0] smoothed;
        logic          last_of_frame;
    } t_smooth_result;

    // Every input is driven to a known value from time zero.
    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx        = REG_FRAME_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  sample_valid   = 1'b0;
    logic signed [SW-1:0]  sample_in      = '0;
    logic                  result_ready   = 1'b0;
    logic                  sample_ready;
    logic                  result_valid;
    logic signed [SW-1:0]  smoothed;
    logic                  last_of_frame;

    // Sample requests waiting for the driver, and smoothed results still owed by the block.
    logic signed [SW-1:0]  pending_samples [$];
    t_smooth_result        smoothed_due [$];

    int samples_queued     = 0;
    int samples_accepted   = 0;
    int results_seen       = 0;
    int mismatch_count     = 0;
    int cycle_count        = 0;
    int sender_gap_pct     = 0;
    int receiver_stall_pct = 0;
    int sender_gap_left    = 0;
    int receiver_stall_left = 0;
    int long_hold_asks     = 0;
    int long_holds_begun   = 0;

    // Model of the block: configuration, line stores, window taps and raster counters.
    logic [ROWS_W-1:0]     rows_cfg;
    logic [COLS_W-1:0]     cols_cfg;
    logic signed [SW-1:0]  line_a [LINES];
    logic signed [SW-1:0]  line_b [LINES];
    bit                    known_a [LINES];
    bit                    known_b [LINES];
    // tap[row][age]: row 0 is two rows up, row 2 the current row; age 0 is one column back.
    logic signed [SW-1:0]  tap [3][2];
    logic [ROW_CNT_W-1:0]  row_cnt;
    logic [8:0]            col_cnt;

    weighted_smoothing_3x3 i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_sample_valid  (sample_valid),
        .o_sample_ready  (sample_ready),
        .i_sample_in     (sample_in),
        .o_result_valid  (result_valid),
        .i_result_ready  (result_ready),
        .o_smoothed      (smoothed),
        .o_last_of_frame (last_of_frame)
    );

    always begin
        #(HALF_PERIOD) clk = ~clk;
    end

    // Watchdog: a correct run finishes far below this many cycles.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The block clamps both frame sizes to the range it supports.
    function automatic int unsigned rows_in_use(input logic [ROWS_W-1:0] raw);
        if (raw < ROWS_MIN) return int'(ROWS_MIN);
        if (raw > ROWS_MAX) return int'(ROWS_MAX);
        return int'(raw);
    endfunction

    function automatic int unsigned cols_in_use(input logic [COLS_W-1:0] raw);
        if (int'(raw) < COLS_MIN) return COLS_MIN;
        if (int'(raw) > LINES) return LINES;
        return int'(raw);
    endfunction

    // Divide by twelve rounding half toward plus infinity, then clamp to the sample range.
    function automatic logic [SW-1:0] round_saturate(input longint acc);
        longint n;
        longint q;
        n = acc + 6;
        q = n / 12;
        if ((n % 12) != 0 && n < 0) q = q - 1;
        if (q > SAT_HI) q = SAT_HI;
        if (q < SAT_LO) q = SAT_LO;
        return q[SW-1:0];
    endfunction

    // Consumes one accepted sample and queues the result it completes, if any.
    task automatic advance_window(input logic signed [SW-1:0] sample);
        int unsigned          rows_n;
        int unsigned          cols_n;
        logic signed [SW-1:0] above2;
        logic signed [SW-1:0] above1;
        longint               acc;
        bit                   col_end;
        bit                   row_end;
        t_smooth_result       res;
        rows_n  = rows_in_use(rows_cfg);
        cols_n  = cols_in_use(cols_cfg);
        col_end = (int'(col_cnt) >= int'(cols_n) - 1);
        row_end = (int'(row_cnt) >= int'(rows_n) - 1);
        above2  = line_b[col_cnt];
        above1  = line_a[col_cnt];
        // Only a window whose centre is an interior pixel yields a result.
        if (row_cnt >= 2 && col_cnt >= 2) begin
            acc = longint'(tap[0][1]) + longint'(above2) + longint'(tap[2][1])
                + longint'(sample)
                + 2 * (longint'(tap[0][0]) + longint'(tap[1][1]) + longint'(above1)
                       + longint'(tap[2][0]))
                + 4 * longint'(tap[1][0]);
            res.smoothed      = round_saturate(acc);
            res.last_of_frame = col_end && row_end;
            smoothed_due.push_back(res);
        end
        line_b[col_cnt]  = above1;
        line_a[col_cnt]  = sample;
        known_b[col_cnt] = known_a[col_cnt];
        known_a[col_cnt] = 1'b1;
        tap[0][1] = tap[0][0];
        tap[0][0] = above2;
        tap[1][1] = tap[1][0];
        tap[1][0] = above1;
        tap[2][1] = tap[2][0];
        tap[2][0] = sample;
        // A counter past its (possibly new) last index wraps after this sample.
        if (col_end) begin
            col_cnt = '0;
            row_cnt = row_end ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endtask

    // Driver. A request, once offered, stays put until the block takes it; between
    // requests the driver may idle for a random burst of cycles.
    always @(posedge clk) begin : drive_requests
        logic                 nxt_valid;
        logic signed [SW-1:0] nxt_sample;
        if (!rst_n) begin
            sample_valid    <= 1'b0;
            sender_gap_left = 0;
        end else begin
            nxt_valid  = sample_valid;
            nxt_sample = sample_in;
            if (sample_valid && sample_ready) begin
                advance_window(sample_in);
                samples_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (sender_gap_left > 0) begin
                    sender_gap_left--;
                end else if (pending_samples.size() > 0) begin
                    if (sender_gap_pct > 0 && $urandom_range(1, 100) <= sender_gap_pct) begin
                        // This cycle is the first of the idle burst.
                        sender_gap_left = $urandom_range(1, 11) - 1;
                    end else begin
                        nxt_valid  = 1'b1;
                        nxt_sample = pending_samples.pop_front();
                    end
                end
            end
            sample_valid <= nxt_valid;
            sample_in    <= nxt_sample;
        end
    end

    // Monitor. Each result request taken by the testbench is checked against the
    // oldest outstanding prediction. Ready is withdrawn in random bursts, and once
    // for a long stretch so that the block backs up into its input.
    always @(posedge clk) begin : check_results
        t_smooth_result want;
        logic           nxt_ready;
        if (!rst_n) begin
            result_ready        <= 1'b0;
            receiver_stall_left = 0;
        end else begin
            if (result_valid && result_ready) begin
                results_seen++;
                if (smoothed_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d unexpected: smoothed %0d last %0b",
                                 results_seen, smoothed, last_of_frame);
                    end
                end else begin
                    want = smoothed_due.pop_front();
                    if (smoothed !== want.smoothed
                        || last_of_frame !== want.last_of_frame) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d: expected %0d last %0b, got %0d last %0b",
                                     results_seen, $signed(want.smoothed),
                                     want.last_of_frame, smoothed, last_of_frame);
                        end
                    end
                end
            end
            nxt_ready = 1'b1;
            if (receiver_stall_left > 0) begin
                receiver_stall_left--;
                nxt_ready = 1'b0;
            end else if (long_hold_asks != long_holds_begun) begin
                long_holds_begun++;
                receiver_stall_left = LONG_HOLD - 1;
                nxt_ready = 1'b0;
            end else if (receiver_stall_pct > 0
                         && $urandom_range(1, 100) <= receiver_stall_pct) begin
                receiver_stall_left = $urandom_range(1, 11) - 1;
                nxt_ready = 1'b0;
            end
            result_ready <= nxt_ready;
        end
    end

    task automatic queue_sample(input logic signed [SW-1:0] value);
        pending_samples.push_back(value);
        samples_queued++;
    endtask

    // Each call writes one register, and only while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_ROWS) begin
            rows_cfg = data;
        end else begin
            cfg_cols_update: cols_cfg = data[COLS_W-1:0];
        end
    endtask

    // The sender stops until every request is in and every result is out. Border
    // samples leave no result behind them, so a few extra cycles let those settle too.
    task automatic settle();
        while (samples_accepted != samples_queued || smoothed_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Samples lean toward the extremes so that saturation and sign handling get exercised.
    function automatic logic signed [SW-1:0] random_sample();
        int v;
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: begin
                v = $urandom_range(0, 24) - 12;
                return v[SW-1:0];
            end
            3: return SAMPLE_MAX - SW'($urandom_range(0, 255));
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_rows();
        int k;
        k = $urandom_range(0, 99);
        if (k < 65) return CFG_DATA_W'($urandom_range(3, 8));
        if (k < 75) return CFG_DATA_W'($urandom_range(0, 2));
        if (k < 90) return CFG_DATA_W'($urandom_range(9, 40));
        if (k < 95) return CFG_DATA_W'(4096);
        return CFG_DATA_W'($urandom_range(4097, 8191));
    endfunction

    // Bits above the column field are junk that the block has to ignore.
    function automatic logic [CFG_DATA_W-1:0] pick_cols();
        int k;
        int v;
        k = $urandom_range(0, 99);
        if (k < 65) v = $urandom_range(3, 24);
        else if (k < 75) v = $urandom_range(0, 2);
        else if (k < 90) v = $urandom_range(25, 80);
        else if (k < 95) v = LINES;
        else v = $urandom_range(LINES + 1, 1023);
        return {(CFG_DATA_W - COLS_W)'($urandom()), COLS_W'(v)};
    endfunction

    // A wider row mid-frame is only allowed where both line stores already hold data,
    // since the block's stores power up undefined.
    function automatic bit widen_is_safe(input int unsigned new_cols);
        for (int c = 0; c < int'(new_cols); c++) begin
            if (!(known_a[c] && known_b[c])) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Number of samples up to and including the one that ends the current frame.
    function automatic int frame_remaining();
        int r;
        int c;
        int re;
        int ce;
        int n;
        r  = int'(row_cnt);
        c  = int'(col_cnt);
        re = int'(rows_in_use(rows_cfg));
        ce = int'(cols_in_use(cols_cfg));
        for (n = 1; n < 4096 * 512; n++) begin
            if (c >= ce - 1) begin
                if (r >= re - 1) return n;
                r++;
                c = 0;
            end else begin
                c++;
            end
        end
        return n;
    endfunction

    initial begin : stimulus
        int                    count;
        int                    random_items;
        logic [CFG_DATA_W-1:0] new_cols;
        bit                    at_frame_start;

        rows_cfg = ROWS_RESET;
        cols_cfg = COLS_RESET;
        row_cnt  = '0;
        col_cnt  = '0;
        for (int c = 0; c < LINES; c++) begin
            line_a[c]  = '0;
            line_b[c]  = '0;
            known_a[c] = 1'b0;
            known_b[c] = 1'b0;
        end
        for (int r = 0; r < 3; r++) begin
            tap[r][0] = '0;
            tap[r][1] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame with register values below the legal range on both sizes.
        // Full-scale positive input overflows the 4/3 gain and must saturate high.
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(2));
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(0));
        repeat (9) queue_sample(SAMPLE_MAX);
        settle();

        // Full-scale negative input saturates low.
        write_reg(REG_FRAME_ROWS, CFG_DATA_W'(3));
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(2));
        repeat (9) queue_sample(SAMPLE_MIN);
        settle();

        // Rounding ties: a corner of -6 gives -0.5, which rounds up to zero, and a
        // corner of +6 gives +0.5, which rounds up to one.
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(4));
        for (int k = 0; k < 12; k++) begin
            if (k == 0) queue_sample(SW'(-6));
            else if (k == 3) queue_sample(SW'(6));
            else queue_sample('0);
        end
        settle();

        // Widest row: a column value above the store depth with junk in the upper data
        // bits clamps to the full line store. One full row fills line store a, and the
        // frame stops a little into the second row, where the next phase narrows it.
        sender_gap_pct     = 5;
        receiver_stall_pct = 5;
        write_reg(REG_FRAME_COLS, {3'b101, 10'h3FF});
        repeat (LINES + 32) queue_sample(random_sample());
        settle();

        // Back-pressure: the receiver holds off for a long stretch while the sender
        // keeps offering, so the block fills up and stops taking requests. The row
        // narrows mid-frame, so the results show where the wide row wrapped. The row
        // count is set beyond its range and left mid-frame for the random part.
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        write_reg(REG_FRAME_ROWS, 13'h1FFF);
        write_reg(REG_FRAME_COLS, CFG_DATA_W'(20));
        long_hold_asks++;
        repeat (80) queue_sample(random_sample());
        settle();

        // Random phases: new sizes at frame boundaries or mid-frame, then either whole
        // frames or an arbitrary run of samples. The last stretch runs without idling.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= RANDOM_ITEMS - CALM_ITEMS) begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end else begin
                sender_gap_pct     = pick_pct();
                receiver_stall_pct = pick_pct();
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(REG_FRAME_ROWS, pick_rows());
            end
            if ($urandom_range(0, 2) != 0) begin
                new_cols       = pick_cols();
                at_frame_start = (row_cnt == 0 && col_cnt == 0);
                if (at_frame_start
                    || cols_in_use(new_cols[COLS_W-1:0]) <= cols_in_use(cols_cfg)
                    || widen_is_safe(cols_in_use(new_cols[COLS_W-1:0]))) begin
                    write_reg(REG_FRAME_COLS, new_cols);
                end
            end
            if (rows_in_use(rows_cfg) * cols_in_use(cols_cfg) <= 120
                && $urandom_range(0, 3) != 0) begin
                count = frame_remaining();
                if ($urandom_range(0, 1) != 0) begin
                    count += int'(rows_in_use(rows_cfg) * cols_in_use(cols_cfg));
                end
            end else begin
                count = $urandom_range(5, 90);
            end
            repeat (count) queue_sample(random_sample());
            random_items += count;
            settle();
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
